/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VEFC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VEFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VEFC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define VEFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* hdl/vefc_pkg.sv */
// ----------------------------------------------------------------------------
// vefc_pkg
// Field widths, codes and defaults of the vertex elimination fill counter.
// ----------------------------------------------------------------------------
package vefc_pkg;

  localparam int MAX_NODES_DEF = 64;

  localparam int OP_W     = 2;
  localparam int NODE_W   = 6;
  localparam int FILL_W   = 11;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 7;
  localparam int NCOUNT_W = 7;

  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 7'd64;
  localparam logic [FILL_W-1:0]   FILL_MAX       = 11'h7FF;

  // popcount slice width of the fill-in counter
  localparam int CHUNK_W = 32;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;
  localparam logic [OP_W-1:0] OP_ELIM  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ELIM  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SELF  = 2'd3;

endpackage

/* hdl/vefc_req_if.sv */
// ----------------------------------------------------------------------------
// vefc_req_if
// Command channel: op, node_a, node_b with valid/ready.
// ----------------------------------------------------------------------------
interface vefc_req_if;
  import vefc_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, op, node_a, node_b, input ready);
  modport sink   (input valid, op, node_a, node_b, output ready);
endinterface

/* hdl/vefc_rsp_if.sv */
// ----------------------------------------------------------------------------
// vefc_rsp_if
// Result channel: fill count, status, eliminated total and done flag.
// ----------------------------------------------------------------------------
interface vefc_rsp_if;
  import vefc_pkg::*;

  logic                valid;
  logic                ready;
  logic [FILL_W-1:0]   fill_count;
  logic [STATUS_W-1:0] status;
  logic [TOTAL_W-1:0]  eliminated_total;
  logic                all_done;

  modport source (output valid, fill_count, status, eliminated_total, all_done,
                  input ready);
  modport sink   (input valid, fill_count, status, eliminated_total, all_done,
                  output ready);
endinterface

/* hdl/vefc_ram.sv */
// ----------------------------------------------------------------------------
// vefc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vefc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/vertex_elimination_fill_counter.sv */
// ----------------------------------------------------------------------------
// vertex_elimination_fill_counter
// Adjacency matrix in RAM, one row per node; counts fill-in on elimination.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   valid / ready      op, node_a, node_b
//  rsp      out  valid / ready      fill_count, status, eliminated_total, all_done
//  cfg      in   cfg_we             cfg_wdata = node_count
//
//  One item at a time. Error or unused op: goes straight to the result
//  register; add edge: two row read-modify-writes; elimination: zeroes
//  the node's row, then one neighbour row read-modify-write per cycle
//  through the RAM read port.
//  Clear and reset run a zeroing pass over all MAX_NODES rows with req.ready low.
//  A waiting result does not block acceptance; it stalls only the next result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_elimination_fill_counter #(
  parameter int MAX_NODES = vefc_pkg::MAX_NODES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [vefc_pkg::NCOUNT_W-1:0] cfg_wdata,
  vefc_req_if.sink                      req,
  vefc_rsp_if.source                    rsp
);
  import vefc_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCH = (MAX_NODES + CHUNK_W - 1) / CHUNK_W;
  localparam int CCW = $clog2(CHUNK_W + 1);
  localparam int SW  = $clog2(MAX_NODES + 1);
  localparam int AW  = ((SW > FILL_W) ? SW : FILL_W) + 1;

  localparam logic [2:0] S_SWEEP    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_EDGE_A   = 3'd2;
  localparam logic [2:0] S_EDGE_B   = 3'd3;
  localparam logic [2:0] S_ELIM_X   = 3'd4;
  localparam logic [2:0] S_ELIM_RUN = 3'd5;
  localparam logic [2:0] S_RESP     = 3'd6;

  localparam logic [MAX_NODES-1:0] ONE_HOT0 = MAX_NODES'(1);

  logic [2:0]           state;
  logic [NCOUNT_W-1:0]  node_count;
  logic [NW-1:0]        sweep_cnt;
  logic                 clr_resp;
  logic [MAX_NODES-1:0] elim_flags;
  logic [TOTAL_W-1:0]   elim_total;

  logic [NW-1:0]        a_r;
  logic [NW-1:0]        b_r;
  logic [STATUS_W-1:0]  res_status;
  logic [FILL_W-1:0]    fill;
  logic [FILL_W-1:0]    fill_next;
  logic [MAX_NODES-1:0] nbr;
  logic [MAX_NODES-1:0] pend;

  logic                 rd_vld;
  logic [NW-1:0]        rd_node;
  logic [MAX_NODES-1:0] oh_u_r;
  logic                 cnt_vld;
  logic [CCW-1:0]       chunk_cnt [NCH];

  logic                 rsp_valid;
  logic [FILL_W-1:0]    rsp_fill;
  logic [STATUS_W-1:0]  rsp_status;
  logic [TOTAL_W-1:0]   rsp_total;
  logic                 rsp_done;

  logic                 ram_we;
  logic [NW-1:0]        ram_waddr;
  logic [MAX_NODES-1:0] ram_wdata;
  logic [NW-1:0]        ram_raddr;
  logic [MAX_NODES-1:0] ram_rdata;

  logic                 accept;
  logic [NW-1:0]        in_a;
  logic [NW-1:0]        in_b;
  logic                 a_in_range;
  logic                 b_in_range;
  logic [STATUS_W-1:0]  edge_status;
  logic [STATUS_W-1:0]  elim_status;
  logic [MAX_NODES-1:0] oh_a;
  logic [MAX_NODES-1:0] oh_b;
  logic [MAX_NODES-1:0] low;
  logic [NW-1:0]        enc;
  logic                 issue;
  logic [MAX_NODES-1:0] above_u;
  logic [MAX_NODES-1:0] diff;
  logic [NCH*CHUNK_W-1:0] diff_pad;
  logic [SW-1:0]        chunk_sum;
  logic [AW-1:0]        fill_sum;
  logic [MAX_NODES-1:0] in_use;
  logic                 all_done;
  logic                 rsp_free;

  vefc_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp_free = !rsp_valid || rsp.ready;

  assign in_a = NW'(req.node_a);
  assign in_b = NW'(req.node_b);
  assign a_in_range = ({1'b0, req.node_a} < node_count) && (int'(req.node_a) < MAX_NODES);
  assign b_in_range = ({1'b0, req.node_b} < node_count) && (int'(req.node_b) < MAX_NODES);

  always_comb begin
    priority if (!a_in_range || !b_in_range) begin
      edge_status = ST_RANGE;
    end else if (elim_flags[in_a] || elim_flags[in_b]) begin
      edge_status = ST_ELIM;
    end else if (req.node_a == req.node_b) begin
      edge_status = ST_SELF;
    end else begin
      edge_status = ST_OK;
    end
  end

  always_comb begin
    priority if (!a_in_range) begin
      elim_status = ST_RANGE;
    end else if (elim_flags[in_a]) begin
      elim_status = ST_ELIM;
    end else begin
      elim_status = ST_OK;
    end
  end

  assign oh_a = ONE_HOT0 << a_r;
  assign oh_b = ONE_HOT0 << b_r;

  // lowest pending neighbour, isolated and encoded
  assign low   = pend & (~pend + ONE_HOT0);
  assign issue = (state == S_ELIM_RUN) && (pend != '0);

  always_comb begin
    enc = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (low[i]) begin
        enc = enc | NW'(i);
      end
    end
  end

  // new edges of row u: neighbours above u not yet in the row
  assign above_u  = ~(oh_u_r | (oh_u_r - ONE_HOT0));
  assign diff     = nbr & ~ram_rdata & above_u;
  assign diff_pad = (NCH*CHUNK_W)'(diff);

  always_comb begin
    chunk_sum = '0;
    for (int c = 0; c < NCH; c++) begin
      chunk_sum = chunk_sum + SW'(chunk_cnt[c]);
    end
  end

  assign fill_sum  = AW'(fill) + AW'(chunk_sum);
  assign fill_next = (fill_sum > AW'(FILL_MAX)) ? FILL_MAX : FILL_W'(fill_sum);

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      in_use[i] = (i < int'(node_count));
    end
  end

  assign all_done = &(elim_flags | ~in_use);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a_r;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_cnt;
      end
      S_IDLE: begin
        ram_raddr = in_a;
      end
      S_EDGE_A: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | oh_b;
        ram_raddr = b_r;
      end
      S_EDGE_B: begin
        ram_we    = 1'b1;
        ram_waddr = b_r;
        ram_wdata = ram_rdata | oh_a;
      end
      S_ELIM_X: begin
        // zero the eliminated row
        ram_we = 1'b1;
      end
      S_ELIM_RUN: begin
        ram_raddr = enc;
        ram_we    = rd_vld;
        ram_waddr = rd_node;
        ram_wdata = (ram_rdata | nbr) & ~oh_u_r & ~oh_a;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      node_count <= NODE_COUNT_RST;
      sweep_cnt  <= '0;
      clr_resp   <= 1'b0;
      elim_flags <= '0;
      elim_total <= '0;
      rd_vld     <= 1'b0;
      cnt_vld    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      rd_vld  <= issue;
      cnt_vld <= rd_vld;
      if (state == S_RESP && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + NW'(1);
          if (sweep_cnt == NW'(MAX_NODES - 1)) begin
            state <= clr_resp ? S_RESP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (req.op)
              OP_CLEAR: begin
                elim_flags <= '0;
                elim_total <= '0;
                sweep_cnt  <= '0;
                clr_resp   <= 1'b1;
                state      <= S_SWEEP;
              end
              OP_EDGE: begin
                state <= (edge_status == ST_OK) ? S_EDGE_A : S_RESP;
              end
              OP_ELIM: begin
                state <= (elim_status == ST_OK) ? S_ELIM_X : S_RESP;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_EDGE_A: begin
          state <= S_EDGE_B;
        end
        S_EDGE_B: begin
          state <= S_RESP;
        end
        S_ELIM_X: begin
          elim_flags[a_r] <= 1'b1;
          elim_total      <= elim_total + TOTAL_W'(1);
          state           <= S_ELIM_RUN;
        end
        S_ELIM_RUN: begin
          // leave once the last row has been written and counted
          if (pend == '0 && !rd_vld && !cnt_vld) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r  <= in_a;
      b_r  <= in_b;
      fill <= '0;
      unique case (req.op)
        OP_EDGE: res_status <= edge_status;
        OP_ELIM: res_status <= elim_status;
        default: res_status <= ST_OK;
      endcase
    end
    if (state == S_ELIM_X) begin
      nbr  <= ram_rdata & ~oh_a;
      pend <= ram_rdata & ~oh_a;
    end else if (issue) begin
      pend <= pend & ~low;
    end
    if (issue) begin
      rd_node <= enc;
      oh_u_r  <= low;
    end
    if (rd_vld) begin
      for (int c = 0; c < NCH; c++) begin
        chunk_cnt[c] <= CCW'($countones(diff_pad[c*CHUNK_W +: CHUNK_W]));
      end
    end
    if (cnt_vld) begin
      fill <= fill_next;
    end
    if (state == S_RESP && rsp_free) begin
      rsp_fill   <= fill;
      rsp_status <= res_status;
      rsp_total  <= elim_total;
      rsp_done   <= all_done;
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.fill_count       = rsp_fill;
  assign rsp.status           = rsp_status;
  assign rsp.eliminated_total = rsp_total;
  assign rsp.all_done         = rsp_done;

  `VEFC_ASSERT_IMPL(a_no_rw_clash, clk, rst, issue && rd_vld, ram_raddr != ram_waddr, "row read and write collide")
  `VEFC_ASSERT_IMPL(a_total_flags, clk, rst, 1'b1, int'(elim_total) == $countones(elim_flags), "eliminated total disagrees with flags")
  `VEFC_ASSERT_NEXT(a_accept_busy, clk, rst, accept, state != S_IDLE, "accepted item left block idle")
  `VEFC_ASSERT_IMPL(a_fill_ok, clk, rst, rsp_valid && rsp_fill != '0, rsp_status == ST_OK, "fill reported with error status")

endmodule
